@@ hw/rtl/adm_pkg.sv @@
// ----------------------------------------------------------------------------
// adm_pkg
// Shared types and constants of the arcade drive mixer: register indexes,
// drive case codes, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package adm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE    = 3'd5;

  localparam int DEADBAND_W = 15;
  localparam int LENGTH_W   = 16;
  localparam int ELAPSED_W  = 16;

  // input gain is Q1.15, unity at 2^15
  localparam int                SCALE_SHIFT = 15;
  localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 16'h8000;

  // drive case codes
  localparam int CASE_W = 3;
  localparam logic [CASE_W-1:0] CASE_TURN     = 3'd0;
  localparam logic [CASE_W-1:0] CASE_STRAIGHT = 3'd1;
  localparam logic [CASE_W-1:0] CASE_SPIN     = 3'd2;
  localparam logic [CASE_W-1:0] CASE_STOP     = 3'd3;
  localparam logic [CASE_W-1:0] CASE_PROP     = 3'd4;

  // datapath micro operations
  typedef enum logic [3:0] {
    OP_IDLE      = 4'd0,
    OP_LOAD      = 4'd1,
    OP_MUL_SCALE = 4'd2,
    OP_TARGET    = 4'd3,
    OP_MUL_RAMP  = 4'd4,
    OP_DIV_RAMP  = 4'd5,
    OP_STORE     = 4'd6,
    OP_MUL_RAD   = 4'd7,
    OP_RADIUS    = 4'd8,
    OP_MUL_INNER = 4'd9,
    OP_DIV_INNER = 4'd10,
    OP_INNER_END = 4'd11,
    OP_SIMPLE    = 4'd12,
    OP_MUL_PROP  = 4'd13,
    OP_PROP_END  = 4'd14
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   chan;   // 0 throttle, 1 turn
  } dp_cmd_t;

  typedef struct packed {
    logic ramp_zero;
    logic mix_mode;
    logic turn;
    logic den_zero;
    logic div_done;
    logic out_blocked;
  } dp_sts_t;

endpackage

@@ hw/rtl/adm_if.sv @@
// ----------------------------------------------------------------------------
// adm_in_if / adm_out_if
// Valid/ready channels of the drive mixer: stick samples in, wheel
// commands out.
// ----------------------------------------------------------------------------
interface adm_in_if import adm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] throttle_in;
  logic signed [SAMPLE_BITS-1:0] turn_in;
  logic        [ELAPSED_W-1:0]   elapsed_ms;

  modport source (output valid, output throttle_in, output turn_in, output elapsed_ms,
                  input ready);
  modport sink   (input valid, input throttle_in, input turn_in, input elapsed_ms,
                  output ready);
endinterface

interface adm_out_if import adm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_drive;
  logic signed [SAMPLE_BITS-1:0] right_drive;
  logic        [CASE_W-1:0]      drive_case;

  modport source (output valid, output left_drive, output right_drive, output drive_case,
                  input ready);
  modport sink   (input valid, input left_drive, input right_drive, input drive_case,
                  output ready);
endinterface

@@ hw/rtl/adm_div.sv @@
// ----------------------------------------------------------------------------
// adm_div
// Unsigned restoring divider, two quotient bits per cycle. The quotient
// holds after done until the next start.
// ----------------------------------------------------------------------------
module adm_div import adm_pkg::*; #(
  parameter int NUM_W = SAMPLE_BITS_DEF + 17,
  parameter int DEN_W = LENGTH_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int ND   = NUM_W + NUM_W % 2;
  localparam int NCYC = ND / 2;
  localparam int CW   = $clog2(NCYC + 1);

  logic [ND-1:0]    q_sr, q_sr_next;
  logic [DEN_W-1:0] rem, rem_next, den_r;
  logic [CW-1:0]    cnt;

  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] r;
    logic [ND-1:0]    q;
    r = rem;
    q = q_sr;
    for (int i = 0; i < 2; i++) begin
      trial = {r, q[ND-1]};
      q     = {q[ND-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
        q[0]  = 1'b1;
      end
      r = trial[DEN_W-1:0];
    end
    rem_next  = r;
    q_sr_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NCYC);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      q_sr  <= ND'(num);
      den_r <= den;
    end else if (busy) begin
      rem  <= rem_next;
      q_sr <= q_sr_next;
    end
  end

  assign quo = q_sr[NUM_W-1:0];

endmodule

@@ hw/rtl/adm_datapath.sv @@
// ----------------------------------------------------------------------------
// adm_datapath
// Configuration registers, ramp state, one shared multiplier with a
// registered product, the shared divider and the output register.
// ----------------------------------------------------------------------------
module adm_datapath import adm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  input  logic signed [SAMPLE_BITS-1:0] throttle_in,
  input  logic signed [SAMPLE_BITS-1:0] turn_in,
  input  logic        [ELAPSED_W-1:0]   elapsed_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] left_drive,
  output logic signed [SAMPLE_BITS-1:0] right_drive,
  output logic        [CASE_W-1:0]      drive_case,
  input  logic                          wr_en,
  input  logic        [CFG_IDX_W-1:0]   wr_index,
  input  logic        [CFG_DATA_W-1:0]  wr_data
);

  localparam int W   = SAMPLE_BITS;
  localparam int F   = W - 1;
  localparam int MA  = W + 2;
  localparam int MB  = (W > 17) ? W : 17;
  localparam int PW  = MA + MB;
  localparam int XW  = PW + 2;
  localparam int NW  = W + 17;
  localparam int DW  = LENGTH_W + 1;

  localparam logic signed [XW-1:0] S_MAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] S_MIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  // helpers
  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
    if (v > S_MAX_X) return S_MAX_X[W-1:0];
    if (v < S_MIN_X) return S_MIN_X[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic [XW-1:0] mag_x(input logic signed [XW-1:0] v);
    return v[XW-1] ? XW'(-v) : XW'(v);
  endfunction

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    logic signed [W:0] e;
    e = {v[W-1], v};
    if (e[W]) e = -e;
    return e[W-1:0];
  endfunction

  // shift right by k, half away from zero
  function automatic logic signed [XW-1:0] rnd_x(input logic signed [XW-1:0] v,
                                                 input int k);
    logic [XW-1:0] m;
    logic [XW-1:0] q;
    m = mag_x(v);
    q = (m + (XW'(1) << (k - 1))) >> k;
    return v[XW-1] ? -$signed(q) : $signed(q);
  endfunction

  // configuration
  logic [LENGTH_W-1:0]   ramp_time;
  logic [DEADBAND_W-1:0] deadband;
  logic [LENGTH_W-1:0]   max_radius;
  logic [LENGTH_W-1:0]   track_width;
  logic [CFG_DATA_W-1:0] input_scale;
  logic                  mix_mode;

  // state and working registers
  logic signed [W-1:0]         last_th, last_tn;
  logic signed [W-1:0]         th_in_r, tn_in_r;
  logic        [ELAPSED_W-1:0] el_r;
  logic signed [PW-1:0]        prod;
  logic signed [W-1:0]         tgt;
  logic signed [W-1:0]         th_v, tn_v;
  logic        [LENGTH_W-1:0]  radius;
  logic                        div_neg;

  // combinational
  logic signed [MA-1:0] mul_a, factor;
  logic signed [MB-1:0] mul_b;
  logic                 mul_en;
  logic signed [W-1:0]  sample, prev, v_new, inner, other;
  logic signed [W:0]    diff;
  logic signed [XW-1:0] prod_x, quo_x, q_signed, radius_x;
  logic [DW-1:0]        den_sum, div_den;
  logic [NW-1:0]        div_num, quo;
  logic                 div_start, div_busy, div_done;
  logic                 emit;

  assign sample  = cmd.chan ? tn_in_r : th_in_r;
  assign prev    = cmd.chan ? last_tn : last_th;
  assign diff    = {tgt[W-1], tgt} - {prev[W-1], prev};
  assign prod_x  = XW'(prod);
  assign den_sum = {1'b0, radius} + {1'b0, track_width};
  assign factor  = (MA'(1) <<< F) - $signed({1'b0, mag_w(tn_in_r), 1'b0});

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_MUL_SCALE: begin
        mul_a = MA'(sample);
        mul_b = MB'($signed({1'b0, input_scale}));
      end
      OP_MUL_RAMP: begin
        mul_a = MA'(diff);
        mul_b = MB'($signed({1'b0, el_r}));
      end
      OP_MUL_RAD: begin
        mul_a = MA'($signed({1'b0, mag_w(tn_v)}));
        mul_b = MB'($signed({1'b0, max_radius}));
      end
      OP_MUL_INNER: begin
        mul_a = MA'(th_v);
        mul_b = MB'($signed({1'b0, radius}));
      end
      OP_MUL_PROP: begin
        mul_a = factor;
        mul_b = MB'(tgt);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // divider operands
  assign div_start = (cmd.op == OP_DIV_RAMP) || (cmd.op == OP_DIV_INNER);
  assign div_den   = (cmd.op == OP_DIV_RAMP) ? {1'b0, ramp_time} : den_sum;
  assign div_num   = NW'(mag_x(prod_x) + (XW'(div_den) >> 1));

  adm_div #(
    .NUM_W (NW),
    .DEN_W (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  assign quo_x    = XW'(quo);
  assign q_signed = div_neg ? -quo_x : quo_x;
  assign v_new    = (ramp_time == '0) ? tgt : sat_w(XW'(prev) + q_signed);
  assign radius_x = XW'($signed({1'b0, max_radius})) - rnd_x(prod_x, F);
  assign inner    = (den_sum == '0) ? '0 : sat_w(q_signed);
  assign other    = sat_w(rnd_x(prod_x, F));

  assign emit = (cmd.op == OP_SIMPLE) || (cmd.op == OP_INNER_END) ||
                (cmd.op == OP_PROP_END);

  // configuration, ramp state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_time   <= '0;
      deadband    <= '0;
      max_radius  <= '0;
      track_width <= '0;
      input_scale <= SCALE_RESET;
      mix_mode    <= 1'b0;
      last_th     <= '0;
      last_tn     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_RAMP_TIME:   ramp_time   <= wr_data;
          REG_DEADBAND:    deadband    <= wr_data[DEADBAND_W-1:0];
          REG_MAX_RADIUS:  max_radius  <= wr_data;
          REG_TRACK_WIDTH: track_width <= wr_data;
          REG_INPUT_SCALE: input_scale <= wr_data;
          REG_MIX_MODE:    mix_mode    <= wr_data[0];
          default: ;
        endcase
      end
      if (cmd.op == OP_STORE) begin
        if (cmd.chan) last_tn <= v_new;
        else          last_th <= v_new;
      end
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
    case (cmd.op) inside
      OP_LOAD: begin
        th_in_r <= throttle_in;
        tn_in_r <= turn_in;
        el_r    <= elapsed_ms;
      end
      OP_TARGET: tgt <= sat_w(rnd_x(prod_x, SCALE_SHIFT));
      OP_DIV_RAMP, OP_DIV_INNER: div_neg <= prod[PW-1];
      OP_STORE: begin
        // deadband applies to the output of the stage, not the stored value
        if (cmd.chan) tn_v <= (mag_w(v_new) <= deadband) ? '0 : v_new;
        else          th_v <= (mag_w(v_new) <= deadband) ? '0 : v_new;
      end
      OP_RADIUS: radius <= radius_x[LENGTH_W-1:0];
      OP_INNER_END: begin
        if (!tn_v[W-1]) begin
          left_drive  <= th_v;
          right_drive <= inner;
        end else begin
          left_drive  <= inner;
          right_drive <= th_v;
        end
        drive_case <= CASE_TURN;
      end
      OP_SIMPLE: begin
        if (th_v != '0) begin
          left_drive  <= th_v;
          right_drive <= th_v;
          drive_case  <= CASE_STRAIGHT;
        end else if (tn_v != '0) begin
          left_drive  <= tn_v;
          right_drive <= sat_w(-XW'(tn_v));
          drive_case  <= CASE_SPIN;
        end else begin
          left_drive  <= '0;
          right_drive <= '0;
          drive_case  <= CASE_STOP;
        end
      end
      OP_PROP_END: begin
        if (!tn_in_r[W-1]) begin
          left_drive  <= tgt;
          right_drive <= other;
        end else begin
          left_drive  <= other;
          right_drive <= tgt;
        end
        drive_case <= CASE_PROP;
      end
      default: ;
    endcase
  end

  assign sts.ramp_zero   = (ramp_time == '0);
  assign sts.mix_mode    = mix_mode;
  assign sts.turn        = (th_v != '0) && (tn_v != '0);
  assign sts.den_zero    = (den_sum == '0);
  assign sts.div_done    = div_done;
  assign sts.out_blocked = out_valid && !out_ready;

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("result beat lost after emit");

endmodule

@@ hw/rtl/adm_ctrl.sv @@
// ----------------------------------------------------------------------------
// adm_ctrl
// Sequencer of the drive mixer: steps the datapath through scaling, ramping,
// case selection and inner wheel division (or the proportional mix) per item.
// ----------------------------------------------------------------------------
module adm_ctrl import adm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [16:0] {
    S_IDLE       = 17'h00001,
    S_MUL_SCALE  = 17'h00002,
    S_TARGET     = 17'h00004,
    S_MUL_RAMP   = 17'h00008,
    S_DIV_RAMP   = 17'h00010,
    S_WAIT_RAMP  = 17'h00020,
    S_STORE      = 17'h00040,
    S_DECIDE     = 17'h00080,
    S_SIMPLE     = 17'h00100,
    S_MUL_RAD    = 17'h00200,
    S_RADIUS     = 17'h00400,
    S_MUL_INNER  = 17'h00800,
    S_DIV_INNER  = 17'h01000,
    S_WAIT_INNER = 17'h02000,
    S_INNER_END  = 17'h04000,
    S_MUL_PROP   = 17'h08000,
    S_PROP_END   = 17'h10000
  } state_t;

  state_t state, state_next;
  logic   chan, chan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan  <= 1'b0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

  always_comb begin
    state_next = state;
    chan_next  = chan;
    cmd.op     = OP_IDLE;
    cmd.chan   = chan;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          chan_next  = 1'b0;
          state_next = S_MUL_SCALE;
        end
      end
      S_MUL_SCALE: begin
        cmd.op     = OP_MUL_SCALE;
        state_next = S_TARGET;
      end
      S_TARGET: begin
        cmd.op = OP_TARGET;
        if (sts.mix_mode)       state_next = S_MUL_PROP;
        else if (sts.ramp_zero) state_next = S_STORE;
        else                    state_next = S_MUL_RAMP;
      end
      S_MUL_RAMP: begin
        cmd.op     = OP_MUL_RAMP;
        state_next = S_DIV_RAMP;
      end
      S_DIV_RAMP: begin
        cmd.op     = OP_DIV_RAMP;
        state_next = S_WAIT_RAMP;
      end
      S_WAIT_RAMP: begin
        if (sts.div_done) state_next = S_STORE;
      end
      S_STORE: begin
        cmd.op = OP_STORE;
        if (!chan) begin
          chan_next  = 1'b1;
          state_next = S_MUL_SCALE;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = sts.turn ? S_MUL_RAD : S_SIMPLE;
      end
      S_SIMPLE: begin
        if (!sts.out_blocked) begin
          cmd.op     = OP_SIMPLE;
          state_next = S_IDLE;
        end
      end
      S_MUL_RAD: begin
        cmd.op     = OP_MUL_RAD;
        state_next = S_RADIUS;
      end
      S_RADIUS: begin
        cmd.op     = OP_RADIUS;
        state_next = S_MUL_INNER;
      end
      S_MUL_INNER: begin
        // zero radius plus width skips the division, inner wheel gets zero
        cmd.op     = OP_MUL_INNER;
        state_next = sts.den_zero ? S_INNER_END : S_DIV_INNER;
      end
      S_DIV_INNER: begin
        cmd.op     = OP_DIV_INNER;
        state_next = S_WAIT_INNER;
      end
      S_WAIT_INNER: begin
        if (sts.div_done) state_next = S_INNER_END;
      end
      S_INNER_END: begin
        if (!sts.out_blocked) begin
          cmd.op     = OP_INNER_END;
          state_next = S_IDLE;
        end
      end
      S_MUL_PROP: begin
        cmd.op     = OP_MUL_PROP;
        state_next = S_PROP_END;
      end
      S_PROP_END: begin
        if (!sts.out_blocked) begin
          cmd.op     = OP_PROP_END;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_WAIT_RAMP || state == S_WAIT_INNER))
    else $error("divider done outside a wait state");

  a_accept_starts_throttle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL_SCALE && !chan))
    else $error("accepted beat did not start on throttle");

endmodule

@@ hw/rtl/arcade_drive_mixer_with_ramp.sv @@
// ----------------------------------------------------------------------------
// arcade_drive_mixer_with_ramp
// No ramp skips the ramp multiply and divide per channel; a straight, spin or stop result
//   skips radius and inner wheel division, zero radius plus width skips the division, and
//   mode 1 only scales and mixes. Throughput: one item at a time, next beat taken in the
//   cycle after the result is loaded; a held output stalls the last step. Reset (rst,
//   synchronous) restores register defaults and clears ramp state and output valid.
// ----------------------------------------------------------------------------
module arcade_drive_mixer_with_ramp import adm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  adm_in_if.sink                in_ch,
  adm_out_if.source             out_ch,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  adm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  adm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .throttle_in (in_ch.throttle_in),
    .turn_in     (in_ch.turn_in),
    .elapsed_ms  (in_ch.elapsed_ms),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .left_drive  (out_ch.left_drive),
    .right_drive (out_ch.right_drive),
    .drive_case  (out_ch.drive_case),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

endmodule

@@ tb/sv/tb_arcade_drive_mixer_with_ramp.sv @@
// ----------------------------------------------------------------------------
// tb_arcade_drive_mixer_with_ramp
// Self-checking bench for the arcade drive mixer. Stick beats are queued by
// the stimulus process, sent by a clocked driver with random gaps and
// predicted at acceptance. The wheel beats that come back are checked field
// by field against the predicted commands, in order, across many register
// settings in both mix modes.
// ----------------------------------------------------------------------------
module tb_arcade_drive_mixer_with_ramp;
  import adm_pkg::*;

  localparam int     SB           = SAMPLE_BITS_DEF;
  localparam longint Q_ONE        = 64'sd1 <<< (SB - 1);
  localparam longint S_MAX        = Q_ONE - 1;
  localparam longint S_MIN        = -Q_ONE;
  localparam longint GAIN_ONE     = 64'sd1 <<< SCALE_SHIFT;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     SEGMENTS     = 10;
  localparam int     SEG_ITEMS    = 100;
  localparam int     HOLD_AT      = 300;
  localparam int     HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [SB-1:0]        throttle;
    logic [SB-1:0]        turn;
    logic [ELAPSED_W-1:0] elapsed;
  } stick_t;

  typedef struct packed {
    logic [SB-1:0]     left;
    logic [SB-1:0]     right;
    logic [CASE_W-1:0] drv_case;
  } wheel_cmd_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  adm_in_if  #(.SAMPLE_BITS(SB)) stick_if ();
  adm_out_if #(.SAMPLE_BITS(SB)) wheel_if ();

  arcade_drive_mixer_with_ramp #(.SAMPLE_BITS(SB)) uut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (stick_if),
    .out_ch   (wheel_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // register copy and ramp state of the predictor
  longint cfg_ramp     = 0;
  longint cfg_deadband = 0;
  longint cfg_radius   = 0;
  longint cfg_width    = 0;
  longint cfg_scale    = GAIN_ONE;
  longint cfg_mode     = 0;
  longint held_throttle = 0;
  longint held_turn     = 0;

  stick_t     stick_q[$];
  wheel_cmd_t wheel_exp_q[$];

  int n_sent     = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_settings = 0;
  int tx_idle_pct = 24;
  int rx_idle_pct = 72;
  logic rx_hold   = 1'b0;
  bit   hold_done = 1'b0;

  function automatic longint sat_q(longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  // round half away from zero, den > 0
  function automatic longint div_round_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint ramp_value(longint sample, longint prev, longint elapsed);
    longint target;
    target = sat_q(div_round_away(sample * cfg_scale, GAIN_ONE));
    if (cfg_ramp == 0) return target;
    // no cap at the target: a long elapsed time overshoots until saturation
    return sat_q(prev + div_round_away((target - prev) * elapsed, cfg_ramp));
  endfunction

  function automatic longint deadband_cut(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    return (mag <= cfg_deadband) ? 0 : v;
  endfunction

  function automatic longint inner_wheel_cmd(longint outside, longint turn);
    longint mag;
    longint radius;
    longint den;
    mag = (turn < 0) ? -turn : turn;
    radius = cfg_radius - div_round_away(cfg_radius * mag, Q_ONE);
    den = radius + cfg_width;
    if (den <= 0) return 0;
    return sat_q(div_round_away(outside * radius, den));
  endfunction

  function automatic wheel_cmd_t mix_sticks(stick_t s);
    longint th_in;
    longint tn_in;
    longint el;
    longint th;
    longint tn;
    longint l;
    longint r;
    logic [CASE_W-1:0] dc;
    wheel_cmd_t res;
    th_in = longint'($signed(s.throttle));
    tn_in = longint'($signed(s.turn));
    el = longint'(s.elapsed);
    if (cfg_mode != 0) begin
      th = sat_q(div_round_away(th_in * cfg_scale, GAIN_ONE));
      if (tn_in >= 0) begin
        l = th;
        r = sat_q(div_round_away(th * (Q_ONE - 2 * tn_in), Q_ONE));
      end else begin
        l = sat_q(div_round_away(th * (Q_ONE + 2 * tn_in), Q_ONE));
        r = th;
      end
      dc = CASE_PROP;
    end else begin
      held_throttle = ramp_value(th_in, held_throttle, el);
      held_turn = ramp_value(tn_in, held_turn, el);
      th = deadband_cut(held_throttle);
      tn = deadband_cut(held_turn);
      if (th != 0 && tn != 0) begin
        if (tn > 0) begin
          l = th;
          r = inner_wheel_cmd(th, tn);
        end else begin
          l = inner_wheel_cmd(th, tn);
          r = th;
        end
        dc = CASE_TURN;
      end else if (th != 0) begin
        l = th;
        r = th;
        dc = CASE_STRAIGHT;
      end else if (tn != 0) begin
        l = tn;
        r = sat_q(-tn);
        dc = CASE_SPIN;
      end else begin
        l = 0;
        r = 0;
        dc = CASE_STOP;
      end
    end
    res.left = l[SB-1:0];
    res.right = r[SB-1:0];
    res.drv_case = dc;
    return res;
  endfunction

  // stick driver, predicts each beat as it is taken
  always @(posedge clk) begin : stick_driver
    stick_t cur;
    stick_t nxt;
    if (rst) begin
      stick_if.valid <= 1'b0;
    end else begin
      if (stick_if.valid && stick_if.ready) begin
        cur.throttle = stick_if.throttle_in;
        cur.turn = stick_if.turn_in;
        cur.elapsed = stick_if.elapsed_ms;
        wheel_exp_q.push_back(mix_sticks(cur));
        n_accepted++;
      end
      if (!stick_if.valid || stick_if.ready) begin
        if (stick_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = stick_q.pop_front();
          stick_if.valid <= 1'b1;
          stick_if.throttle_in <= nxt.throttle;
          stick_if.turn_in <= nxt.turn;
          stick_if.elapsed_ms <= nxt.elapsed;
        end else begin
          stick_if.valid <= 1'b0;
        end
      end
    end
  end

  // wheel monitor and checker
  always @(posedge clk) begin : wheel_monitor
    wheel_cmd_t got;
    wheel_cmd_t want;
    if (rst) begin
      wheel_if.ready <= 1'b0;
    end else begin
      if (wheel_if.valid && wheel_if.ready) begin
        got.left = wheel_if.left_drive;
        got.right = wheel_if.right_drive;
        got.drv_case = wheel_if.drive_case;
        n_results++;
        if (wheel_exp_q.size() == 0) begin
          if (n_errors < 10)
            $display("unexpected wheel beat: left=%0d right=%0d case=%0d",
                     $signed(got.left), $signed(got.right), got.drv_case);
          n_errors++;
        end else begin
          want = wheel_exp_q.pop_front();
          if (got.left != want.left || got.right != want.right ||
              got.drv_case != want.drv_case) begin
            if (n_errors < 10) begin
              $display("wheel beat %0d mismatch: exp left=%0d right=%0d case=%0d",
                       n_results, $signed(want.left), $signed(want.right), want.drv_case);
              $display("  got left=%0d right=%0d case=%0d",
                       $signed(got.left), $signed(got.right), got.drv_case);
            end
            n_errors++;
          end
        end
      end
      wheel_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    while (n_accepted < HOLD_AT) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
    hold_done = 1'b1;
  end

  initial begin
    #2000000;
    $display("tb_arcade_drive_mixer_with_ramp NOT OK");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_RAMP_TIME:   cfg_ramp = longint'(data);
      REG_DEADBAND:    cfg_deadband = longint'(data[DEADBAND_W-1:0]);
      REG_MAX_RADIUS:  cfg_radius = longint'(data);
      REG_TRACK_WIDTH: cfg_width = longint'(data);
      REG_INPUT_SCALE: cfg_scale = longint'(data);
      REG_MIX_MODE:    cfg_mode = longint'(data[0]);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] ramp, logic [15:0] db, logic [15:0] rad,
                            logic [15:0] wid, logic [15:0] scale, logic mode);
    write_reg(REG_RAMP_TIME, ramp);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_MAX_RADIUS, rad);
    write_reg(REG_TRACK_WIDTH, wid);
    write_reg(REG_INPUT_SCALE, scale);
    write_reg(REG_MIX_MODE, {15'd0, mode});
    n_settings++;
  endtask

  task automatic pick_random_setting();
    logic [15:0] ramp;
    logic [15:0] db;
    logic [15:0] rad;
    logic [15:0] wid;
    logic [15:0] scale;
    case ($urandom_range(4))
      0: ramp = 16'd0;
      1: ramp = 16'd1;
      2: ramp = 16'hFFFF;
      3: ramp = 16'($urandom_range(1, 300));
      default: ramp = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: db = 16'd0;
      1: db = 16'd32767;
      2: db = 16'($urandom_range(0, 500));
      default: db = 16'($urandom_range(0, 32767));
    endcase
    case ($urandom_range(3))
      0: rad = 16'd0;
      1: rad = 16'hFFFF;
      default: rad = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: wid = 16'd0;
      1: wid = 16'hFFFF;
      default: wid = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0: scale = 16'h8000;
      1: scale = 16'd0;
      2: scale = 16'hFFFF;
      default: scale = 16'($urandom_range(0, 32768));
    endcase
    set_config(ramp, db, rad, wid, scale, $urandom_range(3) == 0);
  endtask

  task automatic queue_stick(logic [SB-1:0] th, logic [SB-1:0] tn, logic [ELAPSED_W-1:0] el);
    stick_t s;
    s.throttle = th;
    s.turn = tn;
    s.elapsed = el;
    stick_q.push_back(s);
    n_sent++;
  endtask

  // every queued beat answered, then let the datapath settle
  task automatic wait_idle();
    while (n_results < n_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SB-1:0] rand_sample();
    int m;
    case ($urandom_range(9))
      0: return {1'b1, {(SB-1){1'b0}}};
      1: return {1'b0, {(SB-1){1'b1}}};
      2: begin
        m = int'($urandom_range(0, 400)) - 200;
        return m[SB-1:0];
      end
      3: begin
        // just around the deadband edge
        m = int'(cfg_deadband) + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(1) == 1) m = -m;
        return m[SB-1:0];
      end
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] rand_elapsed();
    if (cfg_ramp == 0) return ELAPSED_W'($urandom);
    case ($urandom_range(7))
      0: return '0;
      1: return ELAPSED_W'($urandom);
      2: return cfg_ramp[ELAPSED_W-1:0];
      default: return ELAPSED_W'($urandom_range(0, int'(cfg_ramp)));
    endcase
  endfunction

  initial begin
    int seg;
    int k;
    int run_len;
    logic [SB-1:0] tgt_th;
    logic [SB-1:0] tgt_tn;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_RAMP_TIME;
    wr_data = '0;
    stick_if.valid = 1'b0;
    stick_if.throttle_in = '0;
    stick_if.turn_in = '0;
    stick_if.elapsed_ms = '0;
    wheel_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values: no ramp, no deadband, zero radius and width
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 1'b0);
    queue_stick(16'h7FFF, 16'h0000, 16'd0);
    queue_stick(16'h8000, 16'h0000, 16'd0);
    queue_stick(16'h0000, 16'h7FFF, 16'd0);
    queue_stick(16'h0000, 16'h8000, 16'd0);    // spin, negation saturates
    queue_stick(16'h0000, 16'h0000, 16'd0);
    queue_stick(16'h7FFF, 16'h7FFF, 16'hFFFF); // turn, zero denominator
    queue_stick(16'h8000, 16'h8000, 16'd1);
    wait_idle();

    // ramp, gain above one
    set_config(16'd1000, 16'd100, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
    queue_stick(16'h7FFF, 16'h8000, 16'd500);
    queue_stick(16'd50, 16'd50, 16'd0);
    queue_stick(16'd1, 16'd1, 16'hFFFF);       // overshoot past the target
    queue_stick(16'h8000, 16'h7FFF, 16'd2000);
    wait_idle();

    // zero gain, widest deadband, one ms ramp
    set_config(16'd1, 16'd32767, 16'd1, 16'hFFFF, 16'd0, 1'b0);
    queue_stick(16'h7FFF, 16'h7FFF, 16'hFFFF);
    queue_stick(16'h8000, 16'h8000, 16'd3);
    queue_stick(16'h1234, 16'hFEDC, 16'd0);
    wait_idle();

    // proportional mode
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 1'b1);
    queue_stick(16'h7FFF, 16'h7FFF, 16'hFFFF);
    queue_stick(16'h7FFF, 16'h8000, 16'd0);
    queue_stick(16'h8000, 16'h0000, 16'd7);
    queue_stick(16'h8000, 16'h8000, 16'd0);
    queue_stick(16'd12345, 16'hFFFF, 16'd0);
    wait_idle();
    set_config(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1);
    queue_stick(16'h7FFF, 16'd16000, 16'd9);
    wait_idle();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        tx_idle_pct = 24;
        rx_idle_pct = 72;
      end else if (seg < 7) begin
        tx_idle_pct = 72;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick_random_setting();
      k = 0;
      while (k < SEG_ITEMS) begin
        if ($urandom_range(4) == 0) begin
          queue_stick(SB'($urandom), SB'($urandom), ELAPSED_W'($urandom));
          k++;
        end else begin
          // hold one stick position for a while so the ramp gets somewhere
          tgt_th = rand_sample();
          tgt_tn = rand_sample();
          run_len = $urandom_range(1, 8);
          repeat (run_len) begin
            queue_stick(tgt_th, tgt_tn, rand_elapsed());
            k++;
          end
        end
      end
      wait_idle();
    end

    $display("%0d stick beats over %0d register settings, %0d wheel beats checked",
             n_accepted, n_settings, n_results);
    $display("both mix modes, gaps on both sides, long output stall %s",
             hold_done ? "seen" : "missed");
    if (n_errors == 0 && wheel_exp_q.size() == 0) begin
      $display("tb_arcade_drive_mixer_with_ramp OK");
    end else begin
      $display("%0d mismatches, %0d beats still expected", n_errors, wheel_exp_q.size());
      $display("tb_arcade_drive_mixer_with_ramp NOT OK");
    end
    $finish;
  end

endmodule

@@ arcade_drive_mixer_with_ramp.f @@
hw/rtl/adm_pkg.sv
hw/rtl/adm_if.sv
hw/rtl/adm_div.sv
hw/rtl/adm_datapath.sv
hw/rtl/adm_ctrl.sv
hw/rtl/arcade_drive_mixer_with_ramp.sv
tb/sv/tb_arcade_drive_mixer_with_ramp.sv
